// File: sv/rgb_mipmap_box_downsample_core_defines.svh
// Assertion macros shared by the downsampler RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef RGB_MIPMAP_BOX_DOWNSAMPLE_CORE_DEFINES_SVH
`define RGB_MIPMAP_BOX_DOWNSAMPLE_CORE_DEFINES_SVH
`ifndef SYNTH
`define RMBD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rmbd assertion failed");
`define RMBD_ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("rmbd assertion failed");
`else
`define RMBD_ASSERT(label, clk, rst_n, prop)
`define RMBD_ASSERT_NORST(label, clk, prop)
`endif
`endif

// File: sv/rmbd_pkg.sv
// Types and constants for the 2x2 box mipmap downsampler.
// No dependencies; used by rmbd_cfg_regs, rmbd_line_store and the top level.
`timescale 1ns / 1ps

package rmbd_pkg;

    localparam int CHAN_W     = 8;
    localparam int PAIR_W     = CHAN_W + 1;
    localparam int DIM_W      = 11;
    localparam int ROW_W      = 10;
    localparam int MAX_HEIGHT = 1024;
    localparam int CFG_IDX_W  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 4'd1;

    localparam logic [DIM_W-1:0] RESET_DIM = 11'd256;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_in_pix;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic              last_in_row;
        logic              last_in_frame;
    } t_out_pix;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [DIM_W-1:0]     value;
    } t_cfg_wr;

    typedef struct packed {
        logic [PAIR_W-1:0] r;
        logic [PAIR_W-1:0] g;
        logic [PAIR_W-1:0] b;
    } t_pair_sum;

    // Frame geometry derived from the configuration, plus the restart strobe.
    typedef struct packed {
        logic             restart;
        logic [DIM_W-1:0] w_m1;
        logic [DIM_W-1:0] half_w_m1;
        logic [DIM_W-1:0] h_m1;
        logic [DIM_W-1:0] half_h_m1;
    } t_frame_ctl;

endpackage

// File: sv/rmbd_stream_if.sv
// Valid/ready channel carrying one payload of type T per transfer.
// Depends on nothing; payload types come from rmbd_pkg at instantiation.
`timescale 1ns / 1ps

interface rmbd_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/rmbd_cfg_regs.sv
// Configuration registers: clamps the source size and derives frame geometry.
// Depends on rmbd_pkg and rmbd_stream_if.
`timescale 1ns / 1ps

module rmbd_cfg_regs #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rmbd_stream_if.sink         i_cfg,
    output rmbd_pkg::t_frame_ctl o_ctl
);

    logic [rmbd_pkg::DIM_W-1:0] r_w;
    logic [rmbd_pkg::DIM_W-1:0] r_h;
    logic                       r_restart;
    logic [rmbd_pkg::DIM_W-1:0] n_w;
    logic [rmbd_pkg::DIM_W-1:0] n_h;
    logic                       n_restart;
    logic                       w_wr;
    int unsigned                w_clamp_w;
    int unsigned                w_clamp_h;

    assign i_cfg.ready = 1'b1;
    assign w_wr        = i_cfg.valid;

    always_comb begin
        w_clamp_w = 32'(i_cfg.data.value);
        if (w_clamp_w < 2) begin
            w_clamp_w = 2;
        end else if (w_clamp_w > MAX_WIDTH) begin
            w_clamp_w = MAX_WIDTH;
        end
        w_clamp_h = 32'(i_cfg.data.value);
        if (w_clamp_h < 2) begin
            w_clamp_h = 2;
        end else if (w_clamp_h > rmbd_pkg::MAX_HEIGHT) begin
            w_clamp_h = rmbd_pkg::MAX_HEIGHT;
        end
    end

    always_comb begin
        n_w       = r_w;
        n_h       = r_h;
        n_restart = 1'b0;
        if (w_wr) begin
            case (i_cfg.data.index)
                rmbd_pkg::CFG_SRC_WIDTH: begin
                    n_w       = rmbd_pkg::DIM_W'(w_clamp_w);
                    n_restart = 1'b1;
                end
                rmbd_pkg::CFG_SRC_HEIGHT: begin
                    n_h       = rmbd_pkg::DIM_W'(w_clamp_h);
                    n_restart = 1'b1;
                end
                default: begin
                    n_restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w       <= rmbd_pkg::RESET_DIM;
            r_h       <= rmbd_pkg::RESET_DIM;
            r_restart <= 1'b0;
        end else begin
            r_w       <= n_w;
            r_h       <= n_h;
            r_restart <= n_restart;
        end
    end

    // The counters are cleared in the same cycle as the register write.
    assign o_ctl.restart   = n_restart;
    assign o_ctl.w_m1      = r_w - 1'b1;
    assign o_ctl.half_w_m1 = (r_w >> 1) - 1'b1;
    assign o_ctl.h_m1      = r_h - 1'b1;
    assign o_ctl.half_h_m1 = (r_h >> 1) - 1'b1;

    `include "rgb_mipmap_box_downsample_core_defines.svh"

    `RMBD_ASSERT(a_restart_after_write, i_clk, i_rst_n, r_restart |-> $past(w_wr))
    `RMBD_ASSERT(a_width_legal, i_clk, i_rst_n, (r_w >= 2) && (r_w <= MAX_WIDTH))
    `RMBD_ASSERT(a_height_legal, i_clk, i_rst_n, (r_h >= 2) && (r_h <= rmbd_pkg::MAX_HEIGHT))

endmodule

// File: sv/rmbd_line_store.sv
// Line store of per-column pair sums: one write port, one registered read port.
// Depends on rmbd_pkg.
`timescale 1ns / 1ps

module rmbd_line_store #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  rmbd_pkg::t_pair_sum i_wr_data,
    input  logic                i_rd_en,
    input  logic [AW-1:0]       i_rd_addr,
    output rmbd_pkg::t_pair_sum o_rd_data
);

    rmbd_pkg::t_pair_sum r_mem [DEPTH];
    rmbd_pkg::t_pair_sum r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/rgb_mipmap_box_downsample_core.sv
// Top level of the 2x2 box mipmap downsampler.
// Depends on rmbd_pkg, rmbd_stream_if, rmbd_cfg_regs and rmbd_line_store.
`timescale 1ns / 1ps

// Usage:
// i_pix takes source RGB pixels in raster order, one transfer per pixel.
// o_pix gives one half-size pixel per 2x2 source block, the truncated mean
// of the four samples, with flags on the last pixel of a row and of a frame.
// i_cfg writes the source width (index 0) and height (index 1); any such
// write restarts the frame at the top left. Write only while the stream idles.
// Throughput is one source pixel per cycle. A result is registered and shows
// on o_pix in the cycle after the transfer of the right pixel of the lower
// pair of its block. One output register decouples the two sides: a stalled
// receiver holds the result and i_pix stalls only while that register is full
// and not taken, so a result that is taken frees the stage in the same cycle.
// The pair sums of even rows sit in a single-port-write, single-port-read line
// store; its read is issued on the left pixel of an odd-row pair so the data is
// ready for the right pixel. Odd last columns and rows are consumed silently.
// Reset sets both sizes to 256 and clears the counters; the line store needs
// no clearing since every entry is written on an even row before it is read.

module rgb_mipmap_box_downsample_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rmbd_stream_if.sink   i_pix,
    rmbd_stream_if.source o_pix,
    rmbd_stream_if.sink   i_cfg
);

    // Column counter never has to hold more than an 11-bit width allows.
    localparam int CW    = ($clog2(MAX_WIDTH) < rmbd_pkg::DIM_W) ?
                           $clog2(MAX_WIDTH) : rmbd_pkg::DIM_W;
    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int AW    = ($clog2(DEPTH) > 0) ? $clog2(DEPTH) : 1;

    rmbd_pkg::t_frame_ctl w_ctl;

    logic [CW-1:0]             r_col;
    logic [CW-1:0]             n_col;
    logic [rmbd_pkg::ROW_W-1:0] r_row;
    logic [rmbd_pkg::ROW_W-1:0] n_row;
    rmbd_pkg::t_in_pix         r_left;
    rmbd_pkg::t_in_pix         n_left;
    rmbd_pkg::t_out_pix        r_out;
    rmbd_pkg::t_out_pix        n_out;
    logic                      r_out_valid;
    logic                      n_out_valid;

    logic                      w_acc;
    logic                      w_emit;
    logic                      w_col_last;
    logic                      w_row_last;
    logic [AW-1:0]             w_addr;
    rmbd_pkg::t_pair_sum       w_pair;
    rmbd_pkg::t_pair_sum       w_rd_data;
    logic [rmbd_pkg::PAIR_W:0] w_sum_r;
    logic [rmbd_pkg::PAIR_W:0] w_sum_g;
    logic [rmbd_pkg::PAIR_W:0] w_sum_b;

    rmbd_cfg_regs #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_ctl   (w_ctl)
    );

    // The stage takes a new pixel whenever its result register is free or
    // being emptied in this cycle.
    assign i_pix.ready = !r_out_valid || o_pix.ready;
    assign w_acc       = i_pix.valid && i_pix.ready;
    assign w_emit      = w_acc && r_col[0] && r_row[0];

    assign w_col_last = (rmbd_pkg::DIM_W'(r_col) == w_ctl.w_m1);
    assign w_row_last = (rmbd_pkg::DIM_W'(r_row) == w_ctl.h_m1);
    assign w_addr     = AW'(r_col >> 1);

    // Horizontal pair of the current row.
    assign w_pair.r = {1'b0, r_left.red}   + {1'b0, i_pix.data.red};
    assign w_pair.g = {1'b0, r_left.green} + {1'b0, i_pix.data.green};
    assign w_pair.b = {1'b0, r_left.blue}  + {1'b0, i_pix.data.blue};

    rmbd_line_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (w_acc && r_col[0] && !r_row[0]),
        .i_wr_addr (w_addr),
        .i_wr_data (w_pair),
        .i_rd_en   (w_acc && !r_col[0] && r_row[0]),
        .i_rd_addr (w_addr),
        .o_rd_data (w_rd_data)
    );

    // Vertical add of the stored upper pair and the new lower pair.
    assign w_sum_r = {1'b0, w_rd_data.r} + {1'b0, w_pair.r};
    assign w_sum_g = {1'b0, w_rd_data.g} + {1'b0, w_pair.g};
    assign w_sum_b = {1'b0, w_rd_data.b} + {1'b0, w_pair.b};

    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_left      = r_left;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_pix.ready;
        if (w_ctl.restart) begin
            n_col  = '0;
            n_row  = '0;
            n_left = '0;
        end else if (w_acc) begin
            if (!r_col[0]) begin
                n_left = i_pix.data;
            end
            if (w_col_last) begin
                n_col = '0;
                n_row = w_row_last ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
        if (w_emit) begin
            n_out.out_red       = w_sum_r[rmbd_pkg::PAIR_W:2];
            n_out.out_green     = w_sum_g[rmbd_pkg::PAIR_W:2];
            n_out.out_blue      = w_sum_b[rmbd_pkg::PAIR_W:2];
            n_out.last_in_row   = (rmbd_pkg::DIM_W'(r_col >> 1) == w_ctl.half_w_m1);
            n_out.last_in_frame = n_out.last_in_row &&
                                  (rmbd_pkg::DIM_W'(r_row >> 1) == w_ctl.half_h_m1);
            n_out_valid         = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_pix.valid = r_out_valid;
    assign o_pix.data  = r_out;

    `include "rgb_mipmap_box_downsample_core_defines.svh"

    `RMBD_ASSERT(a_no_emit_without_block, i_clk, i_rst_n, (w_acc && !w_emit) |=> (r_out_valid == $past(r_out_valid && !o_pix.ready)))
    `RMBD_ASSERT(a_full_stage_blocks_input, i_clk, i_rst_n, (r_out_valid && !o_pix.ready) |-> !i_pix.ready)
    `RMBD_ASSERT(a_frame_end_is_row_end, i_clk, i_rst_n, r_out_valid |-> (!r_out.last_in_frame || r_out.last_in_row))
    `RMBD_ASSERT(a_col_in_range, i_clk, i_rst_n, rmbd_pkg::DIM_W'(r_col) <= w_ctl.w_m1)

endmodule
